FILE: rtl/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation pipeline.
// No dependencies; used by the division cells, the divider row and the top level.
`default_nettype none
package bpc_pkg;

	localparam int unsigned DivW   = 32;
	localparam int unsigned CfgAw  = 3;
	localparam int unsigned CfgDw  = 32;

	typedef enum logic [CfgAw-1:0] {
		REG_AC1_AC2 = 3'd0,
		REG_AC3_AC4 = 3'd1,
		REG_AC5_AC6 = 3'd2,
		REG_B1_B2   = 3'd3,
		REG_MC_MD   = 3'd4
	} cfg_reg_t;

	// Constants of the compensation formula
	localparam logic [31:0] K_T_OFFSET = 32'd4000;
	localparam logic [31:0] K_B4_BIAS  = 32'd32768;
	localparam logic [31:0] K_B7_SCALE = 32'd6250;
	localparam logic [31:0] K_P_SQ     = 32'd3038;
	localparam logic [31:0] K_P_LIN    = 32'hFFFF_E343;
	localparam logic [31:0] K_P_OFF    = 32'd3791;

	// Partial state of one division as it moves along the row of cells
	typedef struct packed {
		logic            valid;
		logic [DivW-1:0] rem;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
		logic [DivW-1:0] quo;
	} div_lane_t;

endpackage
`default_nettype wire

FILE: rtl/bpc_div_cell.sv
// One restoring division cell: settles one quotient bit and registers the lane.
// Depends on bpc_pkg.
`default_nettype none
module bpc_div_cell import bpc_pkg::*; #(
	parameter int unsigned SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire div_lane_t         lane_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output div_lane_t              lane_out,
	output logic      [SIDE_W-1:0] side_out
);

	logic [DivW:0]   trial;
	logic [DivW:0]   diff;
	logic            fits;
	div_lane_t       nxt;
	logic            valid_q;
	logic [DivW-1:0] rem_q, num_q, den_q, quo_q;

	always_comb begin
		trial = {lane_in.rem, lane_in.num[DivW-1]};
		diff  = trial - {1'b0, lane_in.den};
		fits  = ~diff[DivW];
		nxt.valid = lane_in.valid;
		nxt.rem   = fits ? diff[DivW-1:0] : trial[DivW-1:0];
		nxt.num   = {lane_in.num[DivW-2:0], 1'b0};
		nxt.den   = lane_in.den;
		nxt.quo   = {lane_in.quo[DivW-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q    <= nxt.rem;
			num_q    <= nxt.num;
			den_q    <= nxt.den;
			quo_q    <= nxt.quo;
			side_out <= side_in;
		end
	end

	always_comb begin
		lane_out.valid = valid_q;
		lane_out.rem   = rem_q;
		lane_out.num   = num_q;
		lane_out.den   = den_q;
		lane_out.quo   = quo_q;
	end

endmodule
`default_nettype wire

FILE: rtl/bpc_divider.sv
// Row of division cells giving an unsigned 32 by 32 bit quotient, one bit per cell.
// Depends on bpc_pkg and bpc_div_cell.
`default_nettype none
module bpc_divider import bpc_pkg::*; #(
	parameter int unsigned SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire logic [DivW-1:0]   num_in,
	input  wire logic [DivW-1:0]   den_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   valid_out,
	output logic      [DivW-1:0]   quo_out,
	output logic      [SIDE_W-1:0] side_out
);

	div_lane_t         lane [DivW+1];
	logic [SIDE_W-1:0] side [DivW+1];

	always_comb begin
		lane[0].valid = valid_in;
		lane[0].rem   = '0;
		lane[0].num   = num_in;
		lane[0].den   = den_in;
		lane[0].quo   = '0;
		side[0]       = side_in;
	end

	for (genvar i = 0; i < DivW; i++) begin : g_cell
		bpc_div_cell #(.SIDE_W(SIDE_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.lane_in  (lane[i]),
			.side_in  (side[i]),
			.lane_out (lane[i+1]),
			.side_out (side[i+1])
		);
	end

	assign valid_out = lane[DivW].valid;
	assign quo_out   = lane[DivW].quo;
	assign side_out  = side[DivW];

endmodule
`default_nettype wire

FILE: rtl/barometric_pressure_compensation_top.sv
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg and bpc_divider.
//
// Usage:
//  s_tdata carries one reading pair per item; m_tdata/m_tuser carry the
//  compensated temperature, pressure and the divide error flag.
//  Calibration words are loaded through cfg_we/cfg_addr/cfg_wdata while
//  the pipeline is empty; an address past the last register is ignored.
//  An accepted input item goes through two front stages, a 32-cell
//  division row for the temperature term, six stages of multiply and
//  add, a 32-cell row for the pressure quotient and three closing
//  stages. One item is accepted each cycle unless the output stalls.
//  The whole pipeline advances together: when a result waits at the
//  output register and m_tready is low, every stage holds and s_tready
//  drops; empty slots hold in place as well, so no bubble is removed.
//  Reset clears all stage valid flags and the calibration registers.
//  A zero divisor in either division sets m_tuser and forces both
//  result fields to zero.
`default_nettype none
module barometric_pressure_compensation_top import bpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [39:0]      s_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [47:0]      m_tdata,   // temperature[15:0], pressure[47:16]
	output logic                  m_tuser,   // divide_error
	input  wire logic             cfg_we,
	input  wire logic [CfgAw-1:0] cfg_addr,
	input  wire logic [CfgDw-1:0] cfg_wdata
);

	logic en;
	logic [31:0] cal_q [5];

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) cal_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_AC1_AC2: cal_q[0] <= cfg_wdata;
				REG_AC3_AC4: cal_q[1] <= cfg_wdata;
				REG_AC5_AC6: cal_q[2] <= cfg_wdata;
				REG_B1_B2:   cal_q[3] <= cfg_wdata;
				REG_MC_MD:   cal_q[4] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		ac1 = {{16{cal_q[0][31]}}, cal_q[0][31:16]};
		ac2 = {{16{cal_q[0][15]}}, cal_q[0][15:0]};
		ac3 = {{16{cal_q[1][31]}}, cal_q[1][31:16]};
		ac4 = {16'd0, cal_q[1][15:0]};
		ac5 = {16'd0, cal_q[2][31:16]};
		ac6 = {16'd0, cal_q[2][15:0]};
		b1  = {{16{cal_q[3][31]}}, cal_q[3][31:16]};
		b2  = {{16{cal_q[3][15]}}, cal_q[3][15:0]};
		mc  = {{16{cal_q[4][31]}}, cal_q[4][31:16]};
		md  = {{16{cal_q[4][15]}}, cal_q[4][15:0]};
	end

	// Whole pipeline moves when the output slot is free or being taken
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	// Stage 1: (UT - AC6) * AC5
	logic        v_s1;
	logic [31:0] prod_s1;
	logic [18:0] up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ({16'd0, s_tdata[15:0]} - ac6) * ac5;
			up_s1   <= s_tdata[39:21];
		end
	end

	// Stage 2: X1, divisor, signs and magnitudes for the temperature division
	logic        v_s2;
	logic [31:0] x1_t, den_t, num_t;
	logic [31:0] x1_s2, nabs_s2, dabs_s2;
	logic [18:0] up_s2;
	logic        neg_s2, err_s2;

	always_comb begin
		x1_t  = 32'($signed(prod_s1) >>> 15);
		den_t = x1_t + md;
		num_t = {mc[20:0], 11'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2   <= x1_t;
			nabs_s2 <= num_t[31] ? -num_t : num_t;
			dabs_s2 <= den_t[31] ? -den_t : den_t;
			neg_s2  <= num_t[31] ^ den_t[31];
			err_s2  <= (den_t == 32'd0);
			up_s2   <= up_s1;
		end
	end

	// Temperature division row
	localparam int unsigned SideW1 = 32 + 19 + 1 + 1;
	logic              v_d1;
	logic [31:0]       q_d1;
	logic [SideW1-1:0] side_d1;
	logic [31:0]       x1_d1;
	logic [18:0]       up_d1;
	logic              neg_d1, err_d1;

	bpc_divider #(.SIDE_W(SideW1)) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s2),
		.num_in    (nabs_s2),
		.den_in    (dabs_s2),
		.side_in   ({x1_s2, up_s2, neg_s2, err_s2}),
		.valid_out (v_d1),
		.quo_out   (q_d1),
		.side_out  (side_d1)
	);
	assign {x1_d1, up_d1, neg_d1, err_d1} = side_d1;

	// Stage 3: B5, temperature, B6
	logic        v_s3;
	logic [31:0] b5_t, b6_s3;
	logic [15:0] t_s3;
	logic [18:0] up_s3;
	logic        err_s3;

	always_comb b5_t = x1_d1 + (neg_d1 ? -q_d1 : q_d1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_d1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b6_s3  <= b5_t - K_T_OFFSET;
			t_s3   <= 16'($signed(b5_t + 32'd8) >>> 4);
			up_s3  <= up_d1;
			err_s3 <= err_d1;
		end
	end

	// Stage 4: B6 squared, AC2*B6, AC3*B6
	logic        v_s4;
	logic [31:0] sq_s4, m2_s4, m3_s4;
	logic [15:0] t_s4;
	logic [18:0] up_s4;
	logic        err_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4  <= b6_s3 * b6_s3;
			m2_s4  <= ac2 * b6_s3;
			m3_s4  <= ac3 * b6_s3;
			t_s4   <= t_s3;
			up_s4  <= up_s3;
			err_s4 <= err_s3;
		end
	end

	// Stage 5: B2*B6sq and B1*B6sq
	logic        v_s5;
	logic [31:0] b6sq_t;
	logic [31:0] mb2_s5, mb1_s5, m2_s5, m3_s5;
	logic [15:0] t_s5;
	logic [18:0] up_s5;
	logic        err_s5;

	always_comb b6sq_t = 32'($signed(sq_s4) >>> 12);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mb2_s5 <= b2 * b6sq_t;
			mb1_s5 <= b1 * b6sq_t;
			m2_s5  <= m2_s4;
			m3_s5  <= m3_s4;
			t_s5   <= t_s4;
			up_s5  <= up_s4;
			err_s5 <= err_s4;
		end
	end

	// Stage 6: B3 and the B4 multiplicand
	logic        v_s6;
	logic [31:0] x3a_t, x3b_t, b3s_t, b3_s6, x3_s6;
	logic [15:0] t_s6;
	logic [18:0] up_s6;
	logic        err_s6;

	always_comb begin
		x3a_t = 32'($signed(mb2_s5) >>> 11) + 32'($signed(m2_s5) >>> 11);
		x3b_t = 32'($signed(m3_s5) >>> 13) + 32'($signed(mb1_s5) >>> 16) + 32'd2;
		b3s_t = {ac1[29:0], 2'b00} + x3a_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			// shift left by three within 32 bits and add the rounding two
			b3_s6  <= 32'($signed({b3s_t[28:0], 3'b010}) >>> 2);
			x3_s6  <= 32'($signed(x3b_t) >>> 2) + K_B4_BIAS;
			t_s6   <= t_s5;
			up_s6  <= up_s5;
			err_s6 <= err_s5;
		end
	end

	// Stage 7: B4 and B7
	logic        v_s7;
	logic [31:0] b4p_t, b4_s7, b7_s7;
	logic [15:0] t_s7;
	logic        err_s7;

	always_comb begin
		b4p_t = ac4 * x3_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b4_s7  <= b4p_t >> 15;
			b7_s7  <= ({13'd0, up_s6} - b3_s6) * K_B7_SCALE;
			t_s7   <= t_s6;
			err_s7 <= err_s6;
		end
	end

	// Stage 8: choose the dividend form for large B7
	logic        v_s8;
	logic [31:0] n_s8, d_s8;
	logic [15:0] t_s8;
	logic        err_s8, big_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s8   <= b7_s7[31] ? b7_s7 : {b7_s7[30:0], 1'b0};
			d_s8   <= b4_s7;
			big_s8 <= b7_s7[31];
			err_s8 <= err_s7 | (b4_s7 == 32'd0);
			t_s8   <= t_s7;
		end
	end

	// Pressure division row
	localparam int unsigned SideW2 = 16 + 1 + 1;
	logic              v_d2;
	logic [31:0]       q_d2;
	logic [SideW2-1:0] side_d2;
	logic [15:0]       t_d2;
	logic              big_d2, err_d2;

	bpc_divider #(.SIDE_W(SideW2)) u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s8),
		.num_in    (n_s8),
		.den_in    (d_s8),
		.side_in   ({t_s8, big_s8, err_s8}),
		.valid_out (v_d2),
		.quo_out   (q_d2),
		.side_out  (side_d2)
	);
	assign {t_d2, big_d2, err_d2} = side_d2;

	// Stage 9: (p>>8)^2 and -7357*p
	logic        v_s9;
	logic [31:0] p_t, p_s9, pp_s9, m7_s9;
	logic [15:0] t_s9;
	logic        err_s9;

	always_comb p_t = big_d2 ? {q_d2[30:0], 1'b0} : q_d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_d2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pp_s9  <= {8'd0, p_t[31:8]} * {8'd0, p_t[31:8]};
			m7_s9  <= K_P_LIN * p_t;
			p_s9   <= p_t;
			t_s9   <= t_d2;
			err_s9 <= err_d2;
		end
	end

	// Stage 10: X1 * 3038
	logic        v_s10;
	logic [31:0] x1_s10, m7_s10, p_s10;
	logic [15:0] t_s10;
	logic        err_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s10  <= pp_s9 * K_P_SQ;
			m7_s10  <= m7_s9;
			p_s10   <= p_s9;
			t_s10   <= t_s9;
			err_s10 <= err_s9;
		end
	end

	// Stage 11: final pressure correction into the output register
	logic [31:0] corr_t, pout_t;

	always_comb begin
		corr_t = 32'($signed(x1_s10) >>> 16) + 32'($signed(m7_s10) >>> 16) + K_P_OFF;
		pout_t = p_s10 + 32'($signed(corr_t) >>> 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_s10;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= err_s10 ? 48'd0 : {pout_t, t_s10};
			m_tuser <= err_s10;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bpc_checker.sv
// Port-level checks for the compensation pipeline, bound to the top level.
// Depends on bpc_pkg and barometric_pressure_compensation_top.
`default_nettype none
module bpc_checker import bpc_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic [39:0]      s_tdata,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [47:0]      m_tdata,
	input wire logic             m_tuser,
	input wire logic             cfg_we,
	input wire logic [CfgAw-1:0] cfg_addr,
	input wire logic [CfgDw-1:0] cfg_wdata
);

	// An error item carries zeroed results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 48'd0))
		else $error("divide error item with nonzero results");

	// Input side is ready exactly when the output slot can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output slot");

	// A stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result item changed");

	// An offered input item carries known data
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown(s_tdata))
		else $error("input item with unknown data");

	// A calibration write carries a known index and value
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown({cfg_addr, cfg_wdata}))
		else $error("calibration write with unknown index or value");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.cfg_we    (cfg_we),
	.cfg_addr  (cfg_addr),
	.cfg_wdata (cfg_wdata)
);
`default_nettype wire
